// ===== src/alle_pkg.sv =====
package alle_pkg;

  localparam int VAL_W = 32;
  localparam int OP_W  = 3;
  localparam int ST_W  = 2;

  localparam logic [OP_W-1:0] OP_INS_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_INS_END   = 3'd1;
  localparam logic [OP_W-1:0] OP_INS_SORT  = 3'd2;
  localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
  localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_ALL  = 3'd5;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ===== src/alle_link_mem.sv =====
module alle_link_mem #(
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH)-1:0]         wr_addr,
  input  logic [$clog2(DEPTH+1)-1:0]       wr_data,
  input  logic [$clog2(DEPTH)-1:0]         rd_addr,
  output logic [$clog2(DEPTH+1)-1:0]       rd_data
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);

  logic [IW-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [IW-1:0] q_r;
  logic          q_valid_r;
  logic [AW-1:0] q_addr_r;

  // an entry not written since reset reads back as a link to the following slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    q_r       <= mem[rd_addr];
    q_valid_r <= valid_r[rd_addr];
    q_addr_r  <= rd_addr;
  end

  assign rd_data = q_valid_r ? q_r : (IW'(q_addr_r) + IW'(1));

endmodule

// ===== src/array_linked_list_engine.sv =====
// Linked list of signed 32-bit elements held in a store of DEPTH nodes, with
// a free chain that hands out and takes back slots at its head. Each input
// transaction carries an opcode (in_tuser) and a value (in_tdata): insert at
// the front, at the end or in ascending order, delete the first or last node,
// or read the whole list. Every operation answers with one result carrying a
// status (out_tuser) and a value (out_tdata); a read of a non-empty list
// answers with one result per element, tlast on the final one. Opcodes 6 and 7
// are taken and dropped. One transaction is handled at a time; the link and
// value memories give one read per cycle, so the cost follows the walk: insert
// at the front and delete of the first node need no walk, insert at the end,
// sorted insert and delete of the last node walk the list, and a read walks
// it once, one result per element.
module array_linked_list_engine
  import alle_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [2:0]  in_tuser,   // [2:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] value_out
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  localparam int IW = $clog2(DEPTH + 1);
  localparam int AW = $clog2(DEPTH);
  localparam logic [IW-1:0] NIL = IW'(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ALLOC = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_LINK  = 3'd3;
  localparam logic [2:0] S_DEL   = 3'd4;
  localparam logic [2:0] S_FREE  = 3'd5;
  localparam logic [2:0] S_RD    = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [IW-1:0]    cur_r, cur_nxt;
  logic [IW-1:0]    prev_r, prev_nxt;
  logic [IW-1:0]    slot_r, slot_nxt;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  logic [IW-1:0]    free_head_r, free_head_nxt;
  logic [IW-1:0]    list_head_r, list_head_nxt;
  logic [ST_W-1:0]  res_status_r, res_status_nxt;
  logic [VAL_W-1:0] res_value_r, res_value_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]  out_status_r, out_status_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_last_r, out_last_nxt;

  logic             nv_we;
  logic [VAL_W-1:0] value_mem [DEPTH];
  logic [VAL_W-1:0] value_q;

  logic             nl_we;
  logic [IW-1:0]    nl_waddr;
  logic [IW-1:0]    nl_wdata;
  logic [IW-1:0]    next_q;

  logic             emit_ok;
  logic [IW-1:0]    cnt_inc;
  logic             adv;
  logic             walk_on;
  logic [IW-1:0]    stop_prev;
  logic [IW-1:0]    stop_cur;

  assign in_tready = (state_r == S_IDLE);
  assign emit_ok   = !out_valid_r || out_tready;
  assign cnt_inc   = cnt_r + IW'(1);

  always_ff @(posedge clk) begin
    if (nv_we) begin
      value_mem[free_head_r[AW-1:0]] <= in_tdata;
    end
    value_q <= value_mem[cur_nxt[AW-1:0]];
  end

  alle_link_mem #(
    .DEPTH (DEPTH)
  ) u_link_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (nl_we),
    .wr_addr (nl_waddr[AW-1:0]),
    .wr_data (nl_wdata),
    .rd_addr (cur_nxt[AW-1:0]),
    .rd_data (next_q)
  );

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    val_nxt        = val_r;
    cur_nxt        = cur_r;
    prev_nxt       = prev_r;
    slot_nxt       = slot_r;
    cnt_nxt        = cnt_r;
    free_head_nxt  = free_head_r;
    list_head_nxt  = list_head_r;
    res_status_nxt = res_status_r;
    res_value_nxt  = res_value_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    out_last_nxt   = out_last_r;
    nv_we          = 1'b0;
    nl_we          = 1'b0;
    nl_waddr       = slot_r;
    nl_wdata       = NIL;
    adv            = 1'b0;
    walk_on        = 1'b0;
    stop_prev      = prev_r;
    stop_cur       = cur_r;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt         = in_tuser;
          val_nxt        = in_tdata;
          res_value_nxt  = '0;
          res_status_nxt = ST_OK;
          if (in_tuser inside {OP_INS_FRONT, OP_INS_END, OP_INS_SORT}) begin
            if (free_head_r >= NIL) begin
              res_status_nxt = ST_FULL;
              state_nxt      = S_EMIT;
            end else begin
              nv_we     = 1'b1;
              slot_nxt  = free_head_r;
              cur_nxt   = free_head_r;
              state_nxt = S_ALLOC;
            end
          end else if (in_tuser inside {OP_DEL_FIRST, OP_DEL_LAST, OP_READ_ALL}) begin
            if (list_head_r >= NIL) begin
              list_head_nxt  = NIL;
              res_status_nxt = ST_EMPTY;
              state_nxt      = S_EMIT;
            end else begin
              cur_nxt   = list_head_r;
              prev_nxt  = NIL;
              cnt_nxt   = (in_tuser == OP_READ_ALL) ? '0 : IW'(1);
              state_nxt = (in_tuser == OP_READ_ALL) ? S_RD : S_DEL;
            end
          end
        end
      end

      S_ALLOC: begin
        // pop the free chain, then link at the head or start the walk
        free_head_nxt = next_q;
        prev_nxt      = NIL;
        if (op_r == OP_INS_FRONT || list_head_r >= NIL) begin
          nl_we         = 1'b1;
          nl_waddr      = slot_r;
          nl_wdata      = (op_r == OP_INS_END) ? NIL : list_head_r;
          list_head_nxt = slot_r;
          state_nxt     = S_EMIT;
        end else begin
          cur_nxt   = list_head_r;
          cnt_nxt   = '0;
          state_nxt = S_WALK;
        end
      end

      S_WALK: begin
        adv = (op_r == OP_INS_END) || ($signed(value_q) < $signed(val_r));
        if (adv) begin
          walk_on   = (cnt_inc < NIL) && (next_q < NIL);
          stop_prev = cur_r;
          stop_cur  = next_q;
        end
        if (walk_on) begin
          prev_nxt = cur_r;
          cur_nxt  = next_q;
          cnt_nxt  = cnt_inc;
        end else begin
          // the new slot's successor is stop_cur (NIL for an insert at the end); write the new slot's link
          nl_we    = 1'b1;
          nl_waddr = slot_r;
          nl_wdata = (op_r == OP_INS_END) ? NIL : stop_cur;
          prev_nxt = stop_prev;
          if (stop_prev < NIL) begin
            state_nxt = S_LINK;
          end else begin
            list_head_nxt = slot_r;
            state_nxt     = S_EMIT;
          end
        end
      end

      S_LINK: begin
        nl_we     = 1'b1;
        nl_waddr  = prev_r;
        nl_wdata  = slot_r;
        state_nxt = S_EMIT;
      end

      S_DEL: begin
        if (op_r == OP_DEL_FIRST) begin
          res_value_nxt = value_q;
          list_head_nxt = (next_q < NIL) ? next_q : NIL;
          state_nxt     = S_FREE;
        end else if ((cnt_r < NIL) && (next_q < NIL)) begin
          prev_nxt = cur_r;
          cur_nxt  = next_q;
          cnt_nxt  = cnt_inc;
        end else begin
          res_value_nxt = value_q;
          if (prev_r < NIL) begin
            nl_we    = 1'b1;
            nl_waddr = prev_r;
            nl_wdata = NIL;
          end else begin
            list_head_nxt = NIL;
          end
          state_nxt = S_FREE;
        end
      end

      S_FREE: begin
        // push the removed slot onto the free chain
        nl_we         = 1'b1;
        nl_waddr      = cur_r;
        nl_wdata      = free_head_r;
        free_head_nxt = cur_r;
        state_nxt     = S_EMIT;
      end

      S_RD: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_value_nxt  = value_q;
          out_last_nxt   = (next_q >= NIL) || (cnt_inc >= NIL);
          if (out_last_nxt) begin
            state_nxt = S_IDLE;
          end else begin
            cur_nxt = next_q;
            cnt_nxt = cnt_inc;
          end
        end
      end

      S_EMIT: begin
        if (emit_ok) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_value_nxt  = res_value_r;
          out_last_nxt   = 1'b1;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      list_head_r <= NIL;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      list_head_r <= list_head_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    val_r        <= val_nxt;
    cur_r        <= cur_nxt;
    prev_r       <= prev_nxt;
    slot_r       <= slot_nxt;
    res_status_r <= res_status_nxt;
    res_value_r  <= res_value_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_value_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

`ifndef ASSERT_OFF
  a_heads_apart: assert property (@(posedge clk) disable iff (!rst_n)
    (list_head_r < NIL && free_head_r < NIL) |-> list_head_r != free_head_r)
    else $error("list head and free head point at the same slot");

  a_read_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |-> state_r == S_RD)
    else $error("read burst left before its final element");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= NIL)
    else $error("walk counter beyond store depth");

  a_fail_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser != ST_OK) |-> (out_tlast && out_tdata == '0))
    else $error("failed operation result not single or carries data");
`endif

endmodule

// ===== tb/sv/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import alle_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam logic [4:0] NIL = 5'(LIST_DEPTH);
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int ITEMS_PER_PHASE = 108;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [VAL_W-1:0] value;
    logic             last;
  } list_result_t;

  // Shadow of the node store and both chains; predicts results per transaction.
  class list_scoreboard;
    logic signed [31:0] slot_val[LIST_DEPTH];
    logic [4:0]         slot_link[LIST_DEPTH];
    logic [4:0]         free_top;
    logic [4:0]         head;
    list_result_t       expected[$];
    int                 occupancy;
    int                 errors;
    int                 ops_seen;
    int                 results_seen;
    int                 full_hits;
    int                 empty_hits;
    int                 reads;

    function new();
      for (int i = 0; i < LIST_DEPTH; i++) begin
        slot_val[i]  = '0;
        slot_link[i] = 5'(i + 1);
      end
      free_top = '0;
      head     = NIL;
    endfunction

    function void push_result(logic [ST_W-1:0] st, logic [31:0] v, logic lst);
      expected.push_back('{st, v, lst});
    endfunction

    function void note_input(logic [2:0] op, logic signed [31:0] val);
      logic [4:0] s;
      logic [4:0] cur;
      logic [4:0] prev;
      logic [4:0] nx;
      int n;
      if (op <= OP_READ_ALL) ops_seen++;
      case (op)
        OP_INS_FRONT, OP_INS_END, OP_INS_SORT: begin
          if (free_top >= NIL) begin
            full_hits++;
            push_result(ST_FULL, '0, 1'b1);
            return;
          end
          s = free_top;
          free_top = slot_link[s];
          slot_val[s] = val;
          prev = NIL;
          cur = head;
          if (op == OP_INS_END) begin
            for (n = 0; n < LIST_DEPTH && cur < NIL; n++) begin
              prev = cur;
              cur = slot_link[cur];
            end
          end else if (op == OP_INS_SORT) begin
            // stop before the first element that is greater or equal
            for (n = 0; n < LIST_DEPTH && cur < NIL && slot_val[cur] < val; n++) begin
              prev = cur;
              cur = slot_link[cur];
            end
          end
          if (prev < NIL) begin
            slot_link[s] = slot_link[prev];
            slot_link[prev] = s;
          end else begin
            slot_link[s] = head;
            head = s;
          end
          if (op == OP_INS_END) slot_link[s] = NIL;
          occupancy++;
          push_result(ST_OK, '0, 1'b1);
        end
        OP_DEL_FIRST, OP_DEL_LAST: begin
          if (head >= NIL) begin
            head = NIL;
            empty_hits++;
            push_result(ST_EMPTY, '0, 1'b1);
            return;
          end
          prev = NIL;
          cur = head;
          if (op == OP_DEL_LAST) begin
            for (n = 1; n < LIST_DEPTH && slot_link[cur] < NIL; n++) begin
              prev = cur;
              cur = slot_link[cur];
            end
          end
          if (op == OP_DEL_FIRST)
            head = (slot_link[cur] < NIL) ? slot_link[cur] : NIL;
          else if (prev < NIL)
            slot_link[prev] = NIL;
          else
            head = NIL;
          // return the slot to the head of the free chain
          slot_link[cur] = free_top;
          free_top = cur;
          occupancy--;
          push_result(ST_OK, slot_val[cur], 1'b1);
        end
        OP_READ_ALL: begin
          reads++;
          if (head >= NIL) begin
            empty_hits++;
            push_result(ST_EMPTY, '0, 1'b1);
            return;
          end
          n = 0;
          cur = head;
          while (n < LIST_DEPTH && cur < NIL) begin
            nx = slot_link[cur];
            push_result(ST_OK, slot_val[cur], (nx >= NIL) || (n + 1 >= LIST_DEPTH));
            n++;
            cur = nx;
          end
        end
        default: ; // unused opcodes: drop
      endcase
    endfunction

    function void check(list_result_t got);
      list_result_t want;
      results_seen++;
      if (expected.size() == 0) begin
        $display("%0t: unexpected result: expected none, actual status %0d value %0d last %0d",
                 $time, got.status, $signed(got.value), got.last);
        errors++;
        return;
      end
      want = expected.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, actual %0d",
                 $time, want.status, got.status);
        errors++;
      end
      if (got.value !== want.value) begin
        $display("%0t: value mismatch: expected %0d, actual %0d",
                 $time, $signed(want.value), $signed(got.value));
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0d, actual %0d",
                 $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_cycles = 0;

  list_scoreboard sb = new();

  array_linked_list_engine #(.DEPTH(LIST_DEPTH)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check('{out_tuser, out_tdata, out_tlast});
  end

  // Abort when nothing moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired with %0d results outstanding",
               $time, sb.expected.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [31:0] val);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= val;
    do @(posedge clk); while (!in_tready);
    sb.note_input(op, val);
  endtask

  // Hold off the sender until every predicted result has been seen
  task automatic wait_drained();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected.size() != 0) @(negedge clk);
  endtask

  initial begin
    logic [2:0]  op;
    logic [31:0] val;
    bit          filling;
    int          done;
    int          r;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, unused opcodes, extremes, ties in sorted order
    send_item(OP_READ_ALL, 32'h0);
    send_item(OP_DEL_FIRST, 32'h0);
    send_item(OP_DEL_LAST, 32'h0);
    send_item(3'd6, 32'h1234_5678);
    send_item(3'd7, 32'hFFFF_FFFF);
    send_item(OP_INS_SORT, 32'h0000_0005);
    send_item(OP_INS_FRONT, 32'h7FFF_FFFF);
    send_item(OP_INS_END, 32'h8000_0000);
    send_item(OP_INS_SORT, 32'hFFFF_FFFF);
    send_item(OP_INS_SORT, 32'h0000_0000);
    send_item(OP_INS_SORT, 32'hFFFF_FFFF);
    send_item(OP_INS_SORT, 32'h8000_0000);
    send_item(OP_INS_SORT, 32'h7FFF_FFFF);
    send_item(OP_READ_ALL, 32'h0);
    send_item(OP_DEL_LAST, 32'h0);
    send_item(OP_DEL_FIRST, 32'h0);
    send_item(OP_INS_END, 32'h0000_0001);
    send_item(OP_READ_ALL, 32'h0);
    send_item(OP_DEL_LAST, 32'h0);
    send_item(OP_DEL_LAST, 32'h0);
    send_item(OP_DEL_FIRST, 32'h0);
    wait_drained();

    // Random: alternate fill and drain bias so full and empty both recur
    filling = 1'b1;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      done = 0;
      while (done < ITEMS_PER_PHASE) begin
        if (sb.occupancy >= LIST_DEPTH && $urandom_range(3) != 0) filling = 1'b0;
        else if (sb.occupancy == 0) filling = 1'b1;
        else if ($urandom_range(39) == 0) filling = ~filling;
        r = $urandom_range(99);
        if (r < 3)
          op = 3'($urandom_range(7, 6));
        else if (r < 13)
          op = OP_READ_ALL;
        else if (r < (filling ? 78 : 38))
          op = 3'($urandom_range(OP_INS_SORT, OP_INS_FRONT));
        else
          op = 3'($urandom_range(OP_DEL_LAST, OP_DEL_FIRST));
        r = $urandom_range(9);
        case (r)
          0: begin
            case ($urandom_range(3))
              0: val = 32'h7FFF_FFFF;
              1: val = 32'h8000_0000;
              2: val = 32'h0;
              default: val = 32'hFFFF_FFFF;
            endcase
          end
          1, 2, 3, 4: val = 32'($signed($urandom_range(20)) - 10);
          default: val = $urandom;
        endcase
        send_item(op, val);
        if (op <= OP_READ_ALL) done++;
        if (done == ITEMS_PER_PHASE / 2 && op <= OP_READ_ALL) wait_drained();
      end
      wait_drained();
    end

    // Let any stray result surface before the verdict
    repeat (40) @(posedge clk);

    $display("Ran %0d list operations (%0d reads) and checked %0d results,",
             sb.ops_seen, sb.reads, sb.results_seen);
    $display("including %0d store-full and %0d list-empty responses.",
             sb.full_hits, sb.empty_hits);
    if (sb.errors == 0 && sb.expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0t: %0d mismatches, %0d results never arrived",
               $time, sb.errors, sb.expected.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/alle_pkg.sv
src/alle_link_mem.sv
src/array_linked_list_engine.sv
tb/sv/tb.sv
